/* sv/msp_pkg.sv */
// msp_pkg: shared constants, codes and types for the power-iteration block.
// No dependencies; every other file uses it.
`timescale 1ns / 1ps

package msp_pkg;

    localparam int MAX_STATES_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ITER_W            = 16;
    localparam int CFG_IDX_W         = 2;

    typedef logic [1:0] t_op;

    localparam t_op OP_WRITE_ENTRY  = 2'd0;
    localparam t_op OP_WRITE_WEIGHT = 2'd1;
    localparam t_op OP_RUN          = 2'd2;
    localparam t_op OP_NONE         = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STATES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* sv/msp_in_if.sv */
// msp_in_if: input channel (load and run commands) with valid/ready.
// Depends on msp_pkg for defaults.
`timescale 1ns / 1ps

interface msp_in_if #(
    parameter int IDX_W = $clog2(msp_pkg::MAX_STATES_DEF),
    parameter int VAL_W = msp_pkg::FRACTION_BITS_DEF + 1
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
    logic [VAL_W-1:0] entry_value;

    modport source (output valid, operation, row_index, column_index, entry_value,
                    input ready);
    modport sink   (input valid, operation, row_index, column_index, entry_value,
                    output ready);
endinterface

/* sv/msp_out_if.sv */
// msp_out_if: result channel, one probability per beat, valid/ready.
// Depends on msp_pkg for defaults.
`timescale 1ns / 1ps

interface msp_out_if #(
    parameter int IDX_W = $clog2(msp_pkg::MAX_STATES_DEF),
    parameter int VAL_W = msp_pkg::FRACTION_BITS_DEF + 1
) ();
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          state_index;
    logic [VAL_W-1:0]          probability;
    logic                      converged;
    logic [msp_pkg::ITER_W-1:0] iterations_used;
    logic                      last_item;

    modport source (output valid, state_index, probability, converged, iterations_used,
                    last_item, input ready);
    modport sink   (input valid, state_index, probability, converged, iterations_used,
                    last_item, output ready);
endinterface

/* sv/msp_div.sv */
// msp_div: restoring divider, floor(num * 2^F / den) with num <= den,
// one quotient bit per cycle. Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_div #(
    parameter int VAL_W = 17,
    parameter int ACC_W = 38,
    parameter int SUM_W = 42
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ACC_W-1:0]   i_num,
    input  logic [SUM_W-1:0]   i_den,
    output msp_pkg::t_div_stat o_stat,
    output logic [VAL_W-1:0]   o_quot
);
    import msp_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W:0]   r_rem;
    logic [SUM_W-1:0] r_den;
    logic [VAL_W-1:0] r_quot;
    logic [SUM_W:0]   w_trial;
    logic             w_ge;

    // first step yields the integer bit, so no shift
    assign w_trial = (r_cnt == '0) ? r_rem : {r_rem[SUM_W-1:0], 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (SUM_W + 1)'(i_num);
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quot <= {r_quot[VAL_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
endmodule

/* sv/msp_engine.sv */
// msp_engine: matrix/vector memories and the run sequencer (load, normalize,
// multiply-accumulate, convergence check, result readout). Uses msp_div, msp_pkg.
`timescale 1ns / 1ps

module msp_engine #(
    parameter int MAX_STATES = 16,
    parameter int VAL_W      = 17,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  msp_pkg::t_op               i_op,
    input  logic [IDX_W-1:0]           i_row,
    input  logic [IDX_W-1:0]           i_col,
    input  logic [VAL_W-1:0]           i_val,
    input  logic [CNT_W-1:0]           i_n,
    input  logic [msp_pkg::ITER_W-1:0] i_max,
    input  logic [VAL_W-1:0]           i_tol,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [IDX_W-1:0]           o_state_index,
    output logic [VAL_W-1:0]           o_probability,
    output logic                       o_converged,
    output logic [msp_pkg::ITER_W-1:0] o_iterations_used,
    output logic                       o_last_item
);
    import msp_pkg::*;

    localparam int ACC_W  = 2 * VAL_W + IDX_W;
    localparam int SUM_W  = ACC_W + IDX_W;
    localparam int DIST_W = VAL_W + IDX_W + 1;
    localparam int TDEPTH = MAX_STATES * MAX_STATES;
    localparam int TA_W   = $clog2(TDEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LDW  = 4'd1;
    localparam logic [3:0] S_LDW2 = 4'd2;
    localparam logic [3:0] S_NRD  = 4'd3;
    localparam logic [3:0] S_NDAT = 4'd4;
    localparam logic [3:0] S_NDIV = 4'd5;
    localparam logic [3:0] S_NWR  = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_MAC  = 4'd8;
    localparam logic [3:0] S_ORD  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // memories
    logic [VAL_W-1:0] tmem [TDEPTH];
    logic [VAL_W-1:0] wmem [MAX_STATES];
    logic [VAL_W-1:0] cmem [MAX_STATES];
    logic [ACC_W-1:0] amem [MAX_STATES];

    logic [3:0]         r_st;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_j;
    logic               r_init;
    logic               r_done;
    logic               r_issue;
    logic               r_p1_v, r_p1_last, r_p2_v, r_p2_last;
    logic [ITER_W-1:0]  r_it;
    logic [SUM_W-1:0]   r_sum;
    logic [DIST_W-1:0]  r_dist;
    logic [ACC_W-1:0]   r_acc;
    logic [2*VAL_W-1:0] r_prod;
    logic [VAL_W-1:0]   r_q;
    logic [VAL_W-1:0]   r_trd, r_wrd, r_crd;
    logic [ACC_W-1:0]   r_ard;

    logic               w_in_go;
    logic               w_row_ok, w_col_ok;
    logic               w_t_we, w_w_we, w_c_we, w_a_we;
    logic [TA_W-1:0]    w_t_waddr, w_t_raddr;
    logic [IDX_W-1:0]   w_c_raddr;
    logic [ACC_W-1:0]   w_a_wdata;
    logic [ACC_W-1:0]   w_acc_n;
    logic               w_i_last, w_j_last;
    logic [VAL_W-1:0]   w_absdiff;
    logic [ITER_W-1:0]  w_itc;
    logic               w_div_start;
    t_div_stat          w_div_stat;
    logic [VAL_W-1:0]   w_div_q;

    assign o_in_ready = (r_st == S_IDLE);
    assign w_in_go    = i_in_valid && o_in_ready;
    assign w_row_ok   = ({1'b0, i_row} < (IDX_W + 1)'(MAX_STATES));
    assign w_col_ok   = ({1'b0, i_col} < (IDX_W + 1)'(MAX_STATES));
    assign w_t_we     = w_in_go && (i_op == OP_WRITE_ENTRY) && w_row_ok && w_col_ok;
    assign w_w_we     = w_in_go && (i_op == OP_WRITE_WEIGHT) && w_row_ok;
    assign w_t_waddr  = TA_W'(i_row) * TA_W'(MAX_STATES) + TA_W'(i_col);
    // entry T[j][i] for column sweep
    assign w_t_raddr  = TA_W'(r_j) * TA_W'(MAX_STATES) + TA_W'(r_i);
    assign w_c_raddr  = (r_st == S_MAC) ? r_j : r_i;

    assign w_i_last   = ({1'b0, r_i} == CNT_W'(i_n - 1'b1));
    assign w_j_last   = ({1'b0, r_j} == CNT_W'(i_n - 1'b1));
    assign w_acc_n    = r_acc + ACC_W'(r_prod);
    assign w_absdiff  = (r_crd > r_q) ? (r_crd - r_q) : (r_q - r_crd);
    assign w_itc      = r_init ? r_it : (r_it + 1'b1);

    assign w_c_we     = (r_st == S_NWR);
    assign w_a_we     = (r_st == S_LDW2) || ((r_st == S_MAC) && r_p2_v && r_p2_last);
    assign w_a_wdata  = (r_st == S_LDW2) ? ACC_W'(r_wrd) : w_acc_n;
    assign w_div_start = (r_st == S_NDAT) && (r_sum != '0);

    always_ff @(posedge i_clk) begin
        if (w_t_we) tmem[w_t_waddr] <= i_val;
        r_trd <= tmem[w_t_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_w_we) wmem[i_row] <= i_val;
        r_wrd <= wmem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (w_c_we) cmem[r_i] <= r_q;
        r_crd <= cmem[w_c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) amem[r_i] <= w_a_wdata;
        r_ard <= amem[r_i];
    end

    msp_div #(
        .VAL_W (VAL_W),
        .ACC_W (ACC_W),
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_ard),
        .i_den   (r_sum),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (r_p1_v) r_prod <= r_trd * r_crd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_init    <= 1'b0;
            r_done    <= 1'b0;
            r_issue   <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p1_last <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p2_last <= 1'b0;
            r_it      <= '0;
            r_sum     <= '0;
            r_dist    <= '0;
            r_acc     <= '0;
            r_q       <= '0;
        end else begin
            r_p1_v    <= 1'b0;
            r_p2_v    <= r_p1_v;
            r_p2_last <= r_p1_last;
            unique case (r_st)
                S_IDLE: begin
                    if (w_in_go && (i_op == OP_RUN)) begin
                        r_i    <= '0;
                        r_sum  <= '0;
                        r_it   <= '0;
                        r_done <= 1'b0;
                        r_st   <= S_LDW;
                    end
                end
                S_LDW: r_st <= S_LDW2;
                S_LDW2: begin
                    r_sum <= r_sum + SUM_W'(r_wrd);
                    if (w_i_last) begin
                        r_i    <= '0;
                        r_init <= 1'b1;
                        r_dist <= '0;
                        r_st   <= S_NRD;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_LDW;
                    end
                end
                S_NRD: r_st <= S_NDAT;
                S_NDAT: begin
                    if (r_sum == '0) begin
                        // zero total: vector is written all zero
                        r_q  <= '0;
                        r_st <= S_NWR;
                    end else begin
                        r_st <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (w_div_stat.done) begin
                        r_q  <= w_div_q;
                        r_st <= S_NWR;
                    end
                end
                S_NWR: begin
                    if (!r_init) r_dist <= r_dist + DIST_W'(w_absdiff);
                    if (w_i_last) begin
                        r_i  <= '0;
                        r_st <= S_CHK;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_NRD;
                    end
                end
                S_CHK: begin
                    r_it <= w_itc;
                    if (!r_init && (r_dist < DIST_W'(i_tol))) begin
                        r_done <= 1'b1;
                        r_st   <= S_ORD;
                    end else if (w_itc < i_max) begin
                        r_j     <= '0;
                        r_sum   <= '0;
                        r_acc   <= '0;
                        r_issue <= 1'b1;
                        r_st    <= S_MAC;
                    end else begin
                        r_st <= S_ORD;
                    end
                end
                S_MAC: begin
                    if (r_issue) begin
                        r_p1_v    <= 1'b1;
                        r_p1_last <= w_j_last;
                        if (w_j_last) r_issue <= 1'b0;
                        else          r_j     <= r_j + 1'b1;
                    end
                    if (r_p2_v) begin
                        if (r_p2_last) begin
                            r_sum <= r_sum + SUM_W'(w_acc_n);
                            r_acc <= '0;
                            r_j   <= '0;
                            if (w_i_last) begin
                                r_i    <= '0;
                                r_init <= 1'b0;
                                r_dist <= '0;
                                r_st   <= S_NRD;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_issue <= 1'b1;
                            end
                        end else begin
                            r_acc <= w_acc_n;
                        end
                    end
                end
                S_ORD: r_st <= S_OUT;
                S_OUT: begin
                    if (i_out_ready) begin
                        if (w_i_last) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_i  <= r_i + 1'b1;
                            r_st <= S_ORD;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = (r_st == S_OUT);
    assign o_state_index     = r_i;
    assign o_probability     = r_crd;
    assign o_converged       = r_done;
    assign o_iterations_used = r_it;
    assign o_last_item       = w_i_last;

`ifndef SYNTHESIS
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");
    a_it_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |-> (r_it <= i_max))
        else $error("iteration count above limit");
    a_conv_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st == S_OUT) && r_done) |-> (r_it != '0))
        else $error("converged without a step");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> ({1'b0, r_i} < i_n))
        else $error("state index beyond n");
    a_mac_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_v && (r_st != S_MAC)) |-> $past(r_st == S_MAC, 1))
        else $error("product stage alive outside multiply");
`endif
endmodule

/* sv/markov_stationary_power_iteration_top.sv */
// Markov stationary distribution by power iteration: config registers and
// channel wiring. Depends on msp_pkg, msp_in_if, msp_out_if, msp_engine.
//
//  channel   dir  beat carries
//  i_item    in   operation, row_index, column_index, entry_value
//  o_result  out  state_index, probability, converged, iterations_used, last_item
//  i_cfg_*   in   register index and data, write only
//
// Load beats are taken while the engine is idle. A run fetches the weights and
// normalizes (serial divider, one bit a cycle; no division on a zero total), then
// each iteration multiplies (one multiply-accumulate a cycle within a row on the
// matrix memory port, two-stage product pipe) and renormalizes; results follow.
// Input ready is low for the whole run; results hold under stall.
// Reset is synchronous; memories have no reset and no clearing pass.
`timescale 1ns / 1ps

module markov_stationary_power_iteration_top #(
    parameter int MAX_STATES    = msp_pkg::MAX_STATES_DEF,
    parameter int FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF,
    parameter int VAL_W         = FRACTION_BITS + 1,
    parameter int IDX_W         = $clog2(MAX_STATES),
    parameter int CNT_W         = $clog2(MAX_STATES + 1),
    parameter int CFG_W = (VAL_W > msp_pkg::ITER_W) ? VAL_W : msp_pkg::ITER_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    msp_in_if.sink                       i_item,
    msp_out_if.source                    o_result,
    input  logic                         i_cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data
);
    import msp_pkg::*;

    logic [CNT_W-1:0]  r_states;
    logic [ITER_W-1:0] r_max_iter;
    logic [VAL_W-1:0]  r_tol;
    logic [CNT_W-1:0]  w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states   <= CNT_W'(MAX_STATES);
            r_max_iter <= ITER_W'(1000);
            r_tol      <= VAL_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATES:    r_states   <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_ITER:  r_max_iter <= i_cfg_data[ITER_W-1:0];
                CFG_TOLERANCE: r_tol      <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // zero means one state, above the limit means the limit
    assign w_n = (r_states == '0) ? CNT_W'(1) :
                 (r_states > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES) : r_states;

    msp_engine #(
        .MAX_STATES (MAX_STATES),
        .VAL_W      (VAL_W),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_item.valid),
        .o_in_ready        (i_item.ready),
        .i_op              (i_item.operation),
        .i_row             (i_item.row_index),
        .i_col             (i_item.column_index),
        .i_val             (i_item.entry_value),
        .i_n               (w_n),
        .i_max             (r_max_iter),
        .i_tol             (r_tol),
        .o_out_valid       (o_result.valid),
        .i_out_ready       (o_result.ready),
        .o_state_index     (o_result.state_index),
        .o_probability     (o_result.probability),
        .o_converged       (o_result.converged),
        .o_iterations_used (o_result.iterations_used),
        .o_last_item       (o_result.last_item)
    );
endmodule
